### rtl/core/stx_etx_hex_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// stx/etx hex frame decoder assertion macros
// shared concurrent assertion forms for the decoder checker
// ----------------------------------------------------------------------------
`ifndef STX_ETX_HEX_FRAME_DECODER_MACROS_SVH
`define STX_ETX_HEX_FRAME_DECODER_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define SEHFD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sehfd assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SEHFD_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sehfd assertion failed");

`endif

### rtl/core/sehfd_pkg.sv
// ----------------------------------------------------------------------------
// sehfd_pkg
// item types, character codes and hex decode for the stx/etx frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package sehfd_pkg;

    localparam int PAYLOAD_BYTES_DEFAULT = 6;

    localparam logic [7:0] CH_STX         = 8'd2;
    localparam logic [7:0] CH_ETX         = 8'h03;
    localparam logic [7:0] CHAR_ZERO      = 8'd48;
    localparam logic [7:0] DIGIT_MAX      = 8'd9;
    localparam logic [7:0] HEX_LETTER_GAP = 8'd7;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic       fresh_frame;
        logic [7:0] frame_byte_0;
        logic [7:0] frame_byte_1;
        logic [7:0] frame_byte_2;
        logic [7:0] frame_byte_3;
        logic [7:0] frame_byte_4;
        logic [7:0] frame_check_byte;
    } frame_item_t;

    // ascii hex to value, no validation, modulo 256
    function automatic logic [7:0] hex_char_value(input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_ZERO;
        if (d > DIGIT_MAX)
        begin
            d = d - HEX_LETTER_GAP;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sehfd_stream_if.sv
// ----------------------------------------------------------------------------
// sehfd_stream_if
// valid/ready channel carrying one item of a given type
// ----------------------------------------------------------------------------
`default_nettype none

interface sehfd_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/stx_etx_hex_frame_decoder.sv
// output: a result item is shown in the cycle after its byte is accepted
// throughput: one byte per cycle; the single result register is refilled in
//   the cycle it is drained, so ready only drops while a result is stalled
// reset: parser goes idle, byte index, checksum and change flag clear, and the
//   payload store reads all zeros
// ----------------------------------------------------------------------------
// stx_etx_hex_frame_decoder
// decodes stx/etx framed ascii hex payloads with an xor checksum
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_hex_frame_decoder #(
    parameter int PAYLOAD_BYTES = sehfd_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sehfd_stream_if.sink   rx,
    sehfd_stream_if.source frame
);
    import sehfd_pkg::*;

    localparam int IDX_W = $clog2(PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_ETX  = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       hi_reg, hi_next;
    logic [7:0]       xor_reg, xor_next;
    logic             changed_reg, changed_next;
    logic             fresh_reg, fresh_next;
    logic             valid_reg;
    logic [7:0]       store_reg [PAYLOAD_BYTES];

    logic       accept;
    logic [7:0] c;
    logic [7:0] lo_val;
    logic [7:0] pair_val;
    logic       store_we;
    logic [7:0] frame_bytes [5];

    assign accept   = rx.valid && rx.ready;
    assign c        = rx.data.rx_byte;
    assign lo_val   = hex_char_value(c);
    assign pair_val = {hi_reg, 4'b0000} | lo_val;

    assign rx.ready = !valid_reg || frame.ready;

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        hi_next      = hi_reg;
        xor_next     = xor_reg;
        changed_next = changed_reg;
        fresh_next   = 1'b0;
        store_we     = 1'b0;
        priority if (c == CH_STX)
        begin
            phase_next   = PH_HIGH;
            idx_next     = '0;
            hi_next      = '0;
            xor_next     = '0;
            changed_next = 1'b0;
        end
        else if (phase_reg == PH_HIGH)
        begin
            hi_next    = lo_val[3:0];
            phase_next = PH_LOW;
        end
        else if (phase_reg == PH_LOW)
        begin
            store_we = 1'b1;
            idx_next = IDX_W'(idx_reg + 1'b1);
            if (store_reg[idx_reg] != pair_val)
            begin
                changed_next = 1'b1;
            end
            if (idx_reg == LAST_IDX)
            begin
                phase_next = PH_ETX;
            end
            else
            begin
                phase_next = PH_HIGH;
                xor_next   = xor_reg ^ pair_val;
            end
        end
        else if (phase_reg == PH_ETX && c == CH_ETX)
        begin
            phase_next = PH_IDLE;
            idx_next   = '0;
            fresh_next = (xor_reg == store_reg[PAYLOAD_BYTES-1]) && changed_reg;
        end
        else
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            idx_reg     <= '0;
            hi_reg      <= '0;
            xor_reg     <= '0;
            changed_reg <= 1'b0;
            fresh_reg   <= 1'b0;
            valid_reg   <= 1'b0;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                hi_reg      <= hi_next;
                xor_reg     <= xor_next;
                changed_reg <= changed_next;
                fresh_reg   <= fresh_next;
                valid_reg   <= 1'b1;
                if (store_we)
                begin
                    store_reg[idx_reg] <= pair_val;
                end
            end
            else if (frame.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // entries beyond the store read as zero
    for (genvar g = 0; g < 5; g++)
    begin : g_out
        if (g < PAYLOAD_BYTES)
        begin : g_used
            assign frame_bytes[g] = store_reg[g];
        end
        else
        begin : g_zero
            assign frame_bytes[g] = '0;
        end
    end

    assign frame.valid                 = valid_reg;
    assign frame.data.fresh_frame      = fresh_reg;
    assign frame.data.frame_byte_0     = frame_bytes[0];
    assign frame.data.frame_byte_1     = frame_bytes[1];
    assign frame.data.frame_byte_2     = frame_bytes[2];
    assign frame.data.frame_byte_3     = frame_bytes[3];
    assign frame.data.frame_byte_4     = frame_bytes[4];
    assign frame.data.frame_check_byte = store_reg[PAYLOAD_BYTES-1];

endmodule

`default_nettype wire

### rtl/core/sehfd_checker.sv
// ----------------------------------------------------------------------------
// sehfd_checker
// port-level checks on the stx/etx frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "stx_etx_hex_frame_decoder_macros.svh"

module sehfd_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   rx_valid,
    input wire logic                   rx_ready,
    input wire logic [7:0]             rx_byte,
    input wire logic                   frame_valid,
    input wire logic                   frame_ready,
    input wire sehfd_pkg::frame_item_t frame_data
);
    import sehfd_pkg::*;

    logic rx_take;
    logic frame_stall;

    assign rx_take     = rx_valid && rx_ready;
    assign frame_stall = frame_valid && !frame_ready;

    // a stalled result stays offered
    `SEHFD_ASSERT_NEXT(a_frame_hold, clk, rst_n, frame_stall, frame_valid)

    // every accepted byte yields a result in the next cycle
    `SEHFD_ASSERT_NEXT(a_item_result, clk, rst_n, rx_take, frame_valid)

    // only an etx can close a fresh frame
    `SEHFD_ASSERT_NEXT(a_fresh_on_etx, clk, rst_n, rx_take && rx_byte != CH_ETX,
        !frame_data.fresh_frame)

    // the store moves only when a byte is taken
    `SEHFD_ASSERT_NEXT(a_store_quiet, clk, rst_n, !rx_take,
        $stable(frame_data.frame_byte_0) && $stable(frame_data.frame_check_byte))

endmodule

bind stx_etx_hex_frame_decoder sehfd_checker u_sehfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_valid    (rx.valid),
    .rx_ready    (rx.ready),
    .rx_byte     (rx.data.rx_byte),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_data  (frame.data)
);

`default_nettype wire

### dv/tb_stx_etx_hex_frame_decoder_check.sv
// ----------------------------------------------------------------------------
// sehfd_frame_check
// watches both channels of the frame decoder, decodes every accepted byte
// itself and compares each result item field by field with its prediction
// ----------------------------------------------------------------------------
`default_nettype none

module sehfd_frame_check #(
    parameter int NUM_BYTES = sehfd_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rx_valid,
    input  wire logic                   rx_ready,
    input  wire sehfd_pkg::rx_item_t    rx_data,
    input  wire logic                   frame_valid,
    input  wire logic                   frame_ready,
    input  wire sehfd_pkg::frame_item_t frame_data,
    output int                          fail_count,
    output int                          open_count
);
    import sehfd_pkg::*;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_HIGH,
        PARSE_LOW,
        PARSE_ETX
    } parse_phase_t;

    parse_phase_t parse_phase;
    logic [4:0]   byte_slot;
    logic [7:0]   upper_value;
    logic [7:0]   xor_sum;
    logic         payload_changed;
    logic [7:0]   payload [NUM_BYTES];
    frame_item_t  pending_frames [$];
    int           errs;

    function automatic logic [7:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_ZERO;
        if (d > DIGIT_MAX)
        begin
            d = d - HEX_LETTER_GAP;
        end
        return d;
    endfunction

    function automatic logic [7:0] payload_at(input int i);
        return (i < NUM_BYTES) ? payload[i] : 8'h00;
    endfunction

    function automatic frame_item_t decode_byte(input logic [7:0] c);
        frame_item_t r;
        logic [7:0]  v;
        logic        fresh;
        fresh = 1'b0;
        if (c == CH_STX)
        begin
            byte_slot       = '0;
            xor_sum         = '0;
            upper_value     = '0;
            payload_changed = 1'b0;
            parse_phase     = PARSE_HIGH;
        end
        else if (parse_phase == PARSE_HIGH)
        begin
            upper_value = char_value(c);
            parse_phase = PARSE_LOW;
        end
        else if (parse_phase == PARSE_LOW)
        begin
            v           = (upper_value << 4) | char_value(c);
            upper_value = v;
            if (byte_slot < NUM_BYTES)
            begin
                if (payload[byte_slot] != v)
                begin
                    payload_changed = 1'b1;
                end
                payload[byte_slot] = v;
            end
            byte_slot = byte_slot + 5'd1;
            if (byte_slot >= NUM_BYTES)
            begin
                parse_phase = PARSE_ETX;
            end
            else
            begin
                parse_phase = PARSE_HIGH;
                xor_sum     = xor_sum ^ v;
            end
        end
        else if (parse_phase == PARSE_ETX && c == CH_ETX)
        begin
            parse_phase = PARSE_IDLE;
            byte_slot   = '0;
            fresh       = (xor_sum == payload[NUM_BYTES-1]) && payload_changed;
        end
        else
        begin
            parse_phase = PARSE_IDLE;
        end
        r.fresh_frame      = fresh;
        r.frame_byte_0     = payload_at(0);
        r.frame_byte_1     = payload_at(1);
        r.frame_byte_2     = payload_at(2);
        r.frame_byte_3     = payload_at(3);
        r.frame_byte_4     = payload_at(4);
        r.frame_check_byte = payload[NUM_BYTES-1];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_item_t want;
        if (!rst_n)
        begin
            parse_phase     = PARSE_IDLE;
            byte_slot       = '0;
            upper_value     = '0;
            xor_sum         = '0;
            payload_changed = 1'b0;
            for (int i = 0; i < NUM_BYTES; i++)
            begin
                payload[i] = '0;
            end
            pending_frames.delete();
            errs = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
            begin
                pending_frames.push_back(decode_byte(rx_data.rx_byte));
            end
            if (frame_valid && frame_ready)
            begin
                if (pending_frames.size() == 0)
                begin
                    $display("%0t: result item with none pending, actual %h",
                             $time, frame_data);
                    errs++;
                end
                else
                begin
                    want = pending_frames.pop_front();
                    compare_field("fresh_frame", {7'd0, want.fresh_frame},
                                  {7'd0, frame_data.fresh_frame});
                    compare_field("frame_byte_0", want.frame_byte_0, frame_data.frame_byte_0);
                    compare_field("frame_byte_1", want.frame_byte_1, frame_data.frame_byte_1);
                    compare_field("frame_byte_2", want.frame_byte_2, frame_data.frame_byte_2);
                    compare_field("frame_byte_3", want.frame_byte_3, frame_data.frame_byte_3);
                    compare_field("frame_byte_4", want.frame_byte_4, frame_data.frame_byte_4);
                    compare_field("frame_check_byte", want.frame_check_byte,
                                  frame_data.frame_check_byte);
                end
            end
        end
        fail_count <= errs;
        open_count <= pending_frames.size();
    end

endmodule

`default_nettype wire

### dv/tb_stx_etx_hex_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_stx_etx_hex_frame_decoder
// drives framed ascii hex traffic into the decoder: a directed opening, then
// mostly well-formed frames with random payloads, broken frames and noise,
// with random gaps on both channels and one long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stx_etx_hex_frame_decoder;
    import sehfd_pkg::*;

    localparam int         FRAME_BYTES = PAYLOAD_BYTES_DEFAULT;
    localparam int         ITEM_TARGET = 1550;
    localparam logic [7:0] LOWER_CASE  = 8'h20;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   open_count;
    int   sent_count;
    int   cycle_count;
    logic [7:0] last_body [FRAME_BYTES];

    sehfd_stream_if #(.item_t(rx_item_t))    rx_ch ();
    sehfd_stream_if #(.item_t(frame_item_t)) frame_ch ();

    stx_etx_hex_frame_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch)
    );

    sehfd_frame_check #(.NUM_BYTES(FRAME_BYTES)) frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_ch.valid),
        .rx_ready    (rx_ch.ready),
        .rx_data     (rx_ch.data),
        .frame_valid (frame_ch.valid),
        .frame_ready (frame_ch.ready),
        .frame_data  (frame_ch.data),
        .fail_count  (fail_count),
        .open_count  (open_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // output side: random stalls, one long hold-off, one quiet stretch
    initial
    begin
        cycle_count = 0;
        frame_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                cycle_count++;
            end
            if (cycle_count >= 400 && cycle_count < 650)
            begin
                frame_ch.ready <= 1'b0;
            end
            else if (cycle_count >= 1000 && cycle_count < 1400)
            begin
                frame_ch.ready <= 1'b1;
            end
            else
            begin
                frame_ch.ready <= ($urandom_range(99) >= 12);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!(sent_count >= 600 && sent_count < 900) && $urandom_range(99) < 12)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid        <= 1'b1;
        rx_ch.data.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_nibble(input logic [3:0] n);
        logic [7:0] c;
        if ($urandom_range(99) < 3)
        begin
            c = 8'($urandom);
        end
        else if (n > 4'd9)
        begin
            c = CHAR_ZERO + HEX_LETTER_GAP + n;
            if ($urandom_range(99) < 10)
            begin
                c = c | LOWER_CASE;
            end
        end
        else
        begin
            c = CHAR_ZERO + n;
        end
        send_byte(c);
    endtask

    task automatic send_frame();
        logic [7:0] body [FRAME_BYTES];
        logic [7:0] sum;
        bit         reuse;
        reuse = ($urandom_range(99) < 20);
        sum   = '0;
        for (int k = 0; k < FRAME_BYTES - 1; k++)
        begin
            body[k] = reuse ? last_body[k] : 8'($urandom);
            sum     = sum ^ body[k];
        end
        if (reuse)
        begin
            body[FRAME_BYTES-1] = last_body[FRAME_BYTES-1];
        end
        else
        begin
            body[FRAME_BYTES-1] = ($urandom_range(99) < 80) ? sum : 8'($urandom);
        end
        send_byte(CH_STX);
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            send_nibble(body[k][7:4]);
            send_nibble(body[k][3:0]);
            last_body[k] = body[k];
        end
        send_byte(($urandom_range(99) < 85) ? CH_ETX : 8'($urandom));
    endtask

    initial
    begin
        int pick;
        sent_count = 0;
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            last_body[k] = '0;
        end
        rst_n              <= 1'b0;
        rx_ch.valid        <= 1'b0;
        rx_ch.data.rx_byte <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // noise while idle, restart inside a pair, one fresh frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_ETX);
        send_byte(CH_STX);
        send_text("7");
        send_byte(CH_STX);
        send_text("0ABCDEF934A5");
        send_byte(CH_ETX);
        // lowercase pair spills into the upper nibble, then a raw top-bit char
        send_byte(CH_STX);
        send_text("ff");
        send_byte(8'h80);

        while (sent_count < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                send_frame();
            end
            else if (pick < 85)
            begin
                send_byte(CH_STX);
                repeat ($urandom_range(0, 2 * FRAME_BYTES - 1))
                begin
                    send_nibble(4'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_byte(8'($urandom));
                end
            end
        end
        rx_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (open_count != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && open_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/sehfd_pkg.sv
rtl/core/sehfd_stream_if.sv
rtl/core/stx_etx_hex_frame_decoder.sv
rtl/core/sehfd_checker.sv
dv/tb_stx_etx_hex_frame_decoder_check.sv
dv/tb_stx_etx_hex_frame_decoder.sv
